// ----- hw/rtl/lors_pkg.sv -----
// Shared types, constants and saturation helper for the linear ODE stepper.
package lors_pkg;

    // Number formats
    localparam int WORD      = 32;
    localparam int FRAC_BITS = 16;
    localparam int OPND_W    = WORD + 1;     // operand with room for unsigned h
    localparam int PROD_W    = 2 * OPND_W;   // full product width

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd4;

    // Register reset values
    localparam logic [WORD-1:0] END_TIME_RST = 32'd65536;
    localparam logic [WORD-1:0] STEP_RST     = 32'd6554;

    // Input word
    typedef struct packed {
        logic                   restart;
        logic signed [WORD-1:0] source_at_start;
        logic signed [WORD-1:0] source_at_mid;
        logic signed [WORD-1:0] source_at_end;
    } item_t;

    // Result word
    typedef struct packed {
        logic [WORD-1:0]        time_now;
        logic signed [WORD-1:0] value_now;
        logic                   final_step;
        logic                   saturated;
    } result_t;

    // Control of the shared multiply / round / add unit
    typedef struct packed {
        logic half_shift;   // round at FRAC_BITS+1 instead of FRAC_BITS
        logic subtract;     // base minus rounded product
    } mac_ctrl_t;

    // Clipped word plus clip flag
    typedef struct packed {
        logic                   hit;
        logic signed [WORD-1:0] val;
    } sat_t;

    // Clip a wide signed value to the signed word range
    function automatic sat_t sat_word(input logic signed [PROD_W-1:0] x);
        sat_t r;
        logic upper_zero;
        logic upper_ones;
        upper_zero = (x[PROD_W-2:WORD-1] == '0);
        upper_ones = (x[PROD_W-2:WORD-1] == '1);
        r.hit = 1'b0;
        r.val = x[WORD-1:0];
        if (!x[PROD_W-1] && !upper_zero)
        begin
            r.hit = 1'b1;
            r.val = {1'b0, {(WORD-1){1'b1}}};
        end
        else if (x[PROD_W-1] && !upper_ones)
        begin
            r.hit = 1'b1;
            r.val = {1'b1, {(WORD-1){1'b0}}};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/lors_mac.sv -----
// Shared multiplier with round-to-nearest, add or subtract and clip to a word.
module lors_mac (
    input  logic                                  clk,
    input  logic signed [lors_pkg::OPND_W-1:0]    mul_a,
    input  logic signed [lors_pkg::OPND_W-1:0]    mul_b,
    input  lors_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [lors_pkg::WORD-1:0]      base,
    output logic signed [lors_pkg::WORD-1:0]      res,
    output logic                                  clipped
);
    import lors_pkg::*;

    localparam logic signed [PROD_W-1:0] RC_FULL = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] RC_HALF = PROD_W'(1) <<< FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] base_x;
    logic signed [PROD_W-1:0] total;
    sat_t                     clip_out;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Round (ties up), then combine with base and clip
    always_comb
    begin
        biased  = prod_reg + (ctrl.half_shift ? RC_HALF : RC_FULL);
        rounded = ctrl.half_shift ? (biased >>> (FRAC_BITS + 1)) : (biased >>> FRAC_BITS);
        base_x  = PROD_W'(base);
        total   = ctrl.subtract ? (base_x - rounded) : (base_x + rounded);
        clip_out = sat_word(total);
    end

    assign res     = clip_out.val;
    assign clipped = clip_out.hit;

endmodule

// ----- hw/rtl/linear_ode_rk4_euler_stepper.sv -----
// Top level: sequencer for RK4 / forward Euler steps of u' = f(t) - lambda*u.
// RK4 step: eight passes through the one multiplier, each a product state and a round state,
//   with the weighted sum and a base-4096 long division by 3 before the last pass.
// Euler step: two passes through the multiplier. Restart or finished run: straight to the result.
// One word in flight; item_stall is high from acceptance until the result is registered.
// Reset (async, active low): config to defaults, value and time zero, no result pending.
module linear_ode_rk4_euler_stepper (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  lors_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output lors_pkg::result_t                result,
    input  logic                             cfg_wr_en,
    input  logic [lors_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lors_pkg::WORD-1:0]        cfg_data
);
    import lors_pkg::*;

    // Operation codes of the step sequence
    localparam logic [2:0] OP_K1  = 3'd0;
    localparam logic [2:0] OP_T1  = 3'd1;
    localparam logic [2:0] OP_K2  = 3'd2;
    localparam logic [2:0] OP_T2  = 3'd3;
    localparam logic [2:0] OP_K3  = 3'd4;
    localparam logic [2:0] OP_T3  = 3'd5;
    localparam logic [2:0] OP_K4  = 3'd6;
    localparam logic [2:0] OP_UPD = 3'd7;

    // Weighted sum and divide-by-six (floor of sum/2, then base-4096 long division by 3)
    localparam int ACC_W      = 36;
    localparam int DIV_DIGIT  = 12;
    localparam int DIV_DIGITS = ACC_W / DIV_DIGIT;
    localparam int DCNT_W     = $clog2(DIV_DIGITS);
    localparam int DIV_V_W    = DIV_DIGIT + 2;
    localparam int DIV_SHIFT  = DIV_V_W + 1;
    localparam int DIV_PROD_W = DIV_V_W + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV_RECIP = DIV_SHIFT'((2 ** DIV_SHIFT + 2) / 3);
    // +3 rounding term plus 6*2^WORD keeps the sum non-negative
    localparam logic [ACC_W-1:0] ACC_BIAS = ACC_W'(3) + (ACC_W'(6) << WORD);
    localparam logic signed [ACC_W:0] M_BIAS = (ACC_W + 1)'(1) <<< WORD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_SUM,
        ST_DIV,
        ST_LOADM,
        ST_DONE
    } state_t;

    // Configuration registers
    logic                   method_reg;
    logic signed [WORD-1:0] decay_reg;
    logic signed [WORD-1:0] init_reg;
    logic [WORD-1:0]        end_time_reg;
    logic [WORD-1:0]        step_reg;

    // Control state
    state_t                 state_reg;
    logic [2:0]             op_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic [WORD-1:0]        time_reg;
    logic signed [WORD-1:0] value_reg;
    logic                   run_fin_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    // Working registers
    logic signed [WORD-1:0] src_start_reg;
    logic signed [WORD-1:0] src_mid_reg;
    logic signed [WORD-1:0] src_end_reg;
    logic [WORD-1:0]        h_reg;
    logic                   last_reg;
    logic                   hit_reg;
    logic signed [WORD-1:0] t_reg;
    logic signed [WORD-1:0] k_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       div_reg;
    logic [1:0]             rem_reg;

    // Combinational helpers
    logic                   item_accept;
    logic                   result_free;
    logic [WORD-1:0]        remain;
    logic                   ends_run;
    logic [WORD-1:0]        h_sel;
    logic signed [ACC_W-1:0] kx;
    logic [ACC_W-1:0]       acc_sum;
    logic [DIV_V_W-1:0]     div_v;
    logic [DIV_PROD_W-1:0]  div_prod;
    logic [DIV_DIGIT-1:0]   div_q;
    logic [DIV_V_W-1:0]     div_r;
    logic signed [ACC_W:0]  m_wide;
    sat_t                   m_sat;

    logic signed [OPND_W-1:0] mac_a;
    logic signed [OPND_W-1:0] mac_b;
    mac_ctrl_t                mac_ctrl;
    logic signed [WORD-1:0]   mac_base;
    logic signed [WORD-1:0]   mac_res;
    logic                     mac_clip;

    // Handshake
    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_free  = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Step length: full step, or the short last one that lands on end_time
    always_comb
    begin
        remain   = (time_reg < end_time_reg) ? (end_time_reg - time_reg) : '0;
        ends_run = (remain <= step_reg);
        h_sel    = ends_run ? remain : step_reg;
    end

    // Weighted sum and divider digit
    always_comb
    begin
        kx       = ACC_W'(k_reg);
        acc_sum  = acc_reg + $unsigned(kx);
        div_v    = {rem_reg, div_reg[ACC_W-1 -: DIV_DIGIT]};
        div_prod = DIV_PROD_W'(div_v) * DIV_PROD_W'(DIV_RECIP);
        div_q    = div_prod[DIV_SHIFT +: DIV_DIGIT];
        div_r    = div_v - (DIV_V_W'(div_q) << 1) - DIV_V_W'(div_q);
        m_wide   = $signed({1'b0, div_reg}) - M_BIAS;
        m_sat    = sat_word(PROD_W'(m_wide));
    end

    // Operand and base selection for the shared unit
    always_comb
    begin
        if (!op_reg[0])
        begin
            mac_a = OPND_W'(decay_reg);
            mac_b = OPND_W'(t_reg);
        end
        else
        begin
            mac_a = OPND_W'(k_reg);
            mac_b = $signed({1'b0, h_reg});
        end
        mac_ctrl.half_shift = (op_reg == OP_T1) || (op_reg == OP_T2);
        mac_ctrl.subtract   = !op_reg[0];
        case (op_reg) inside
            OP_K1:        mac_base = src_start_reg;
            OP_K2, OP_K3: mac_base = src_mid_reg;
            OP_K4:        mac_base = src_end_reg;
            default:      mac_base = value_reg;
        endcase
    end

    lors_mac u_mac (
        .clk     (clk),
        .mul_a   (mac_a),
        .mul_b   (mac_b),
        .ctrl    (mac_ctrl),
        .base    (mac_base),
        .res     (mac_res),
        .clipped (mac_clip)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg   <= 1'b0;
            decay_reg    <= '0;
            init_reg     <= '0;
            end_time_reg <= END_TIME_RST;
            step_reg     <= STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_METHOD:   method_reg   <= cfg_data[0];
                CFG_DECAY:    decay_reg    <= cfg_data;
                CFG_INIT:     init_reg     <= cfg_data;
                CFG_END_TIME: end_time_reg <= cfg_data;
                CFG_STEP:     step_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequencer, solution state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_K1;
            dcnt_reg         <= '0;
            time_reg         <= '0;
            value_reg        <= '0;
            run_fin_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // the done state reloads the result word itself
            if (result_valid_reg && !result_stall && (state_reg != ST_DONE))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_accept)
                    begin
                        if (item.restart)
                        begin
                            value_reg   <= init_reg;
                            time_reg    <= '0;
                            run_fin_reg <= 1'b0;
                            state_reg   <= ST_DONE;
                        end
                        else if (run_fin_reg)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            time_reg    <= ends_run ? end_time_reg : (time_reg + h_sel);
                            run_fin_reg <= ends_run;
                            op_reg      <= OP_K1;
                            state_reg   <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    if (op_reg == OP_UPD)
                    begin
                        value_reg <= mac_res;
                        state_reg <= ST_DONE;
                    end
                    else if ((op_reg == OP_K1) && method_reg)
                    begin
                        op_reg    <= OP_UPD;
                        state_reg <= ST_MUL;
                    end
                    else if (op_reg == OP_K4)
                    begin
                        state_reg <= ST_SUM;
                    end
                    else
                    begin
                        op_reg    <= op_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SUM:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(DIV_DIGITS - 1))
                    begin
                        state_reg <= ST_LOADM;
                    end
                end
                ST_LOADM:
                begin
                    op_reg    <= OP_UPD;
                    state_reg <= ST_MUL;
                end
                ST_DONE:
                begin
                    if (result_free)
                    begin
                        result_reg.time_now   <= time_reg;
                        result_reg.value_now  <= value_reg;
                        result_reg.final_step <= last_reg;
                        result_reg.saturated  <= hit_reg;
                        result_valid_reg      <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working registers of one step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    src_start_reg <= item.source_at_start;
                    src_mid_reg   <= item.source_at_mid;
                    src_end_reg   <= item.source_at_end;
                    h_reg         <= h_sel;
                    last_reg      <= item.restart ? 1'b0 : (run_fin_reg || ends_run);
                    hit_reg       <= 1'b0;
                    t_reg         <= value_reg;
                end
            end
            ST_MUL:
            begin
                // fold k1, k2 and k3 into the weighted sum while each feeds the multiplier; k4 is added in ST_SUM
                case (op_reg) inside
                    OP_T1:        acc_reg <= ACC_BIAS + $unsigned(kx);
                    OP_T2, OP_T3: acc_reg <= acc_reg + $unsigned(kx <<< 1);
                    default:      ;
                endcase
            end
            ST_RND:
            begin
                case (op_reg) inside
                    OP_K1, OP_K2, OP_K3, OP_K4: k_reg   <= mac_res;
                    OP_T1, OP_T2, OP_T3:        t_reg   <= mac_res;
                    default:                    hit_reg <= mac_clip;
                endcase
            end
            ST_SUM:
            begin
                div_reg <= acc_sum >> 1;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                div_reg <= {div_reg[ACC_W-DIV_DIGIT-1:0], div_q};
                rem_reg <= div_r[1:0];
            end
            ST_LOADM:
            begin
                k_reg <= m_sat.val;
            end
            default: ;
        endcase
    end

endmodule
